// ===== hw/rtl/c2s_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package c2s_pkg;

	localparam int COORD_WIDTH   = 24;
	localparam int ANGLE_WIDTH   = 16;
	localparam int CORDIC_STAGES = 16;

	// Coordinates enter the CORDIC as 61-bit values, so the root chain that
	// builds the guarded planar radius always yields 61 result bits.
	localparam int ROOT_W      = 61;
	localparam int SCALE_SHIFT = ROOT_W - COORD_WIDTH;
	localparam int SQ_W        = 2 * COORD_WIDTH - 1;
	localparam int RAD_W       = 2 * COORD_WIDTH;
	localparam int REM_W       = ROOT_W + 1;
	localparam int DP_W        = 64;
	localparam int ACC_W       = 34;
	localparam int ANG_SHIFT   = 32 - ANGLE_WIDTH;

	localparam logic signed [ACC_W-1:0] HALF_PI_ACC = ACC_W'(64'd1 << 30);
	localparam logic signed [ACC_W-1:0] ANG_RND     = ACC_W'((64'd1 << ANG_SHIFT) >> 1);
	localparam logic signed [ACC_W-1:0] PI_ACC      = ACC_W'(64'd1 << (ANGLE_WIDTH - 1));
	localparam logic [ANGLE_WIDTH-1:0]  PI_CODE     = ANGLE_WIDTH'(64'd1 << (ANGLE_WIDTH - 1));

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x_pos;
		logic signed [COORD_WIDTH-1:0] y_pos;
		logic signed [COORD_WIDTH-1:0] z_pos;
	} point_t;

	typedef struct packed {
		logic [COORD_WIDTH-1:0]        radius;
		logic [COORD_WIDTH-1:0]        planar_radius;
		logic [ANGLE_WIDTH-1:0]        polar_angle;
		logic signed [ANGLE_WIDTH-1:0] azimuth;
		logic                          origin_flag;
	} result_t;

	typedef struct packed {
		logic [RAD_W-1:0]       rad;
		logic [REM_W-1:0]       rem;
		logic [ROOT_W-1:0]      root;
		logic [COORD_WIDTH-1:0] rnd;
	} sq_lane_t;

	typedef struct packed {
		logic signed [DP_W-1:0]  x;
		logic signed [DP_W-1:0]  y;
		logic signed [ACC_W-1:0] acc;
	} cd_lane_t;

	// The arctangent of 2^-i, with pi as 2^31.
	function automatic logic [31:0] atan_entry(input int unsigned idx);
		logic [31:0] v;
		case (idx)
			0:  v = 32'h20000000;
			1:  v = 32'h12E4051D;
			2:  v = 32'h09FB385B;
			3:  v = 32'h051111D4;
			4:  v = 32'h028B0D43;
			5:  v = 32'h0145D7E1;
			6:  v = 32'h00A2F61E;
			7:  v = 32'h00517C55;
			8:  v = 32'h0028BE53;
			9:  v = 32'h00145F2F;
			10: v = 32'h000A2F98;
			11: v = 32'h000517CC;
			12: v = 32'h00028BE6;
			13: v = 32'h000145F3;
			14: v = 32'h0000A2FA;
			15: v = 32'h0000517D;
			16: v = 32'h000028BE;
			17: v = 32'h0000145F;
			18: v = 32'h00000A30;
			19: v = 32'h00000518;
			20: v = 32'h0000028C;
			21: v = 32'h00000146;
			22: v = 32'h000000A3;
			23: v = 32'h00000051;
			24: v = 32'h00000029;
			25: v = 32'h00000014;
			26: v = 32'h0000000A;
			27: v = 32'h00000005;
			28: v = 32'h00000003;
			29: v = 32'h00000001;
			30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/c2s_square.sv =====
`timescale 1ns / 1ps
`default_nettype none

module c2s_square (
	input  wire logic                                   clk,
	input  wire logic                                   en,
	input  wire logic signed [c2s_pkg::COORD_WIDTH-1:0] value,
	output logic [c2s_pkg::SQ_W-1:0]                    square
);

	localparam int CW   = c2s_pkg::COORD_WIDTH;
	localparam int LO_W = CW / 2;
	localparam int HI_W = CW - LO_W;

	logic [CW-1:0]          raw;
	logic [CW-1:0]          mag;
	logic [HI_W-1:0]        mag_hi;
	logic [LO_W-1:0]        mag_lo;
	logic [2*HI_W-1:0]      pp_hh_s1;
	logic [HI_W+LO_W-1:0]   pp_hl_s1;
	logic [2*LO_W-1:0]      pp_ll_s1;
	logic [2*CW-1:0]        full;
	logic [c2s_pkg::SQ_W-1:0] square_s2;

	assign raw    = value;
	assign mag    = raw[CW-1] ? (~raw + CW'(1)) : raw;
	assign mag_hi = mag[CW-1:LO_W];
	assign mag_lo = mag[LO_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			pp_hh_s1 <= (2*HI_W)'(mag_hi) * (2*HI_W)'(mag_hi);
			pp_hl_s1 <= (HI_W+LO_W)'(mag_hi) * (HI_W+LO_W)'(mag_lo);
			pp_ll_s1 <= (2*LO_W)'(mag_lo) * (2*LO_W)'(mag_lo);
		end
	end

	assign full = ((2*CW)'(pp_hh_s1) << (2*LO_W)) + ((2*CW)'(pp_hl_s1) << (LO_W + 1))
		+ (2*CW)'(pp_ll_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			square_s2 <= full[c2s_pkg::SQ_W-1:0];
		end
	end

	assign square = square_s2;

endmodule

`default_nettype wire

// ===== hw/rtl/c2s_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module c2s_sqrt_cell #(
	parameter int IDX = 0
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire c2s_pkg::sq_lane_t lane_in,
	output c2s_pkg::sq_lane_t      lane_out
);

	localparam int RW = c2s_pkg::ROOT_W;
	localparam int CW = c2s_pkg::COORD_WIDTH;

	logic [RW+2:0]      rem_sh;
	logic [RW+2:0]      trial;
	logic [RW+2:0]      diff;
	logic               take;
	logic [RW:0]        rem_new;
	logic [RW-1:0]      root_new;
	c2s_pkg::sq_lane_t  lane_d;
	c2s_pkg::sq_lane_t  lane_q;

	always_comb begin
		rem_sh   = {lane_in.rem, lane_in.rad[c2s_pkg::RAD_W-1 -: 2]};
		trial    = {1'b0, lane_in.root, 2'b01};
		diff     = rem_sh - trial;
		take     = (rem_sh >= trial);
		rem_new  = take ? diff[RW:0] : rem_sh[RW:0];
		root_new = {lane_in.root[RW-2:0], take};

		lane_d.rad  = lane_in.rad << 2;
		lane_d.rem  = rem_new;
		lane_d.root = root_new;
		lane_d.rnd  = lane_in.rnd;
		// The last digit of the integer root also yields the rounded root.
		if (IDX == CW - 1) begin
			lane_d.rnd = root_new[CW-1:0] + CW'(rem_new > {1'b0, root_new});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= lane_d;
		end
	end

	assign lane_out = lane_q;

endmodule

`default_nettype wire

// ===== hw/rtl/c2s_cordic_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module c2s_cordic_cell #(
	parameter int IDX = 0
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire c2s_pkg::cd_lane_t lane_in,
	output c2s_pkg::cd_lane_t      lane_out
);

	localparam int DP_W  = c2s_pkg::DP_W;
	localparam int ACC_W = c2s_pkg::ACC_W;

	logic signed [DP_W-1:0]  x_in;
	logic signed [DP_W-1:0]  y_in;
	logic signed [ACC_W-1:0] acc_in;
	logic signed [DP_W-1:0]  dx;
	logic signed [DP_W-1:0]  dy;
	logic signed [ACC_W-1:0] step;
	c2s_pkg::cd_lane_t       lane_d;
	c2s_pkg::cd_lane_t       lane_q;

	assign x_in   = lane_in.x;
	assign y_in   = lane_in.y;
	assign acc_in = lane_in.acc;
	assign dx     = y_in >>> IDX;
	assign dy     = x_in >>> IDX;
	assign step   = signed'({{(ACC_W-32){1'b0}}, c2s_pkg::atan_entry(IDX)});

	always_comb begin
		if (y_in >= 0) begin
			lane_d.x   = x_in + dx;
			lane_d.y   = y_in - dy;
			lane_d.acc = acc_in + step;
		end else begin
			lane_d.x   = x_in - dx;
			lane_d.y   = y_in + dy;
			lane_d.acc = acc_in - step;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= lane_d;
		end
	end

	assign lane_out = lane_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cartesian_to_spherical_convert.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one request per cycle while the pipeline is not held under result_stall; two
// square stages, a sum stage, the 61-cell root chain, a pre-rotation stage, CORDIC_STAGES
// CORDIC cells and the result register each hold one.
// While a result waits under result_stall the whole pipeline holds and point_stall is high.
// Reset clears the valid bits only; the data registers are not reset.

module cartesian_to_spherical_convert #(
	parameter int CORDIC_STAGES = c2s_pkg::CORDIC_STAGES
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             point_valid,
	output logic                  point_stall,
	input  wire c2s_pkg::point_t  point,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output c2s_pkg::result_t      result
);

	localparam int CW    = c2s_pkg::COORD_WIDTH;
	localparam int AW    = c2s_pkg::ANGLE_WIDTH;
	localparam int RW    = c2s_pkg::ROOT_W;
	localparam int DP_W  = c2s_pkg::DP_W;
	localparam int ACC_W = c2s_pkg::ACC_W;
	localparam int VLD_N = 4 + RW + CORDIC_STAGES;
	localparam int POS_N = 3 + RW;
	localparam int RAD_D = RW - CW;

	typedef struct packed {
		logic [CW-1:0] radius;
		logic [CW-1:0] planar_radius;
		logic          on_axis;
		logic          origin;
		logic          z_neg;
	} side_t;

	logic                      advance;
	logic                      vld_q [VLD_N];
	c2s_pkg::point_t           pos_q [POS_N];
	logic [c2s_pkg::SQ_W-1:0]  sq_x;
	logic [c2s_pkg::SQ_W-1:0]  sq_y;
	logic [c2s_pkg::SQ_W-1:0]  sq_z;
	logic [2*CW-1:0]           pxy_s3;
	logic [2*CW-1:0]           pall_s3;
	c2s_pkg::sq_lane_t         pall_lane [CW+1];
	c2s_pkg::sq_lane_t         pxy_lane [RW+1];
	logic [CW-1:0]             radius_q [RAD_D];
	c2s_pkg::point_t           pos_end;
	logic signed [DP_W-1:0]    sx;
	logic signed [DP_W-1:0]    sy;
	logic signed [DP_W-1:0]    sz;
	logic signed [DP_W-1:0]    srho;
	side_t                     side_d;
	side_t                     side_q [CORDIC_STAGES+1];
	c2s_pkg::cd_lane_t         phi_pre_q;
	c2s_pkg::cd_lane_t         theta_pre_q;
	c2s_pkg::cd_lane_t         phi_lane [CORDIC_STAGES+1];
	c2s_pkg::cd_lane_t         theta_lane [CORDIC_STAGES+1];
	logic signed [ACC_W-1:0]   phi_acc;
	logic signed [ACC_W-1:0]   theta_acc;
	logic signed [ACC_W-1:0]   phi_rnd;
	logic signed [ACC_W-1:0]   theta_rnd;
	side_t                     side_end;
	c2s_pkg::result_t          res_d;
	c2s_pkg::result_t          res_q;
	logic                      res_valid_q;

	function automatic c2s_pkg::cd_lane_t pre_rotate(input logic signed [DP_W-1:0] px,
		input logic signed [DP_W-1:0] py);
		c2s_pkg::cd_lane_t l;
		l.x   = px;
		l.y   = py;
		l.acc = '0;
		if (px < 0) begin
			if (py >= 0) begin
				l.x   = py;
				l.y   = -px;
				l.acc = c2s_pkg::HALF_PI_ACC;
			end else begin
				l.x   = -py;
				l.y   = px;
				l.acc = -c2s_pkg::HALF_PI_ACC;
			end
		end
		return l;
	endfunction

	assign advance     = !(res_valid_q && result_stall);
	assign point_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < VLD_N; k++) begin
				vld_q[k] <= 1'b0;
			end
			res_valid_q <= 1'b0;
		end else if (advance) begin
			vld_q[0] <= point_valid;
			for (int k = 1; k < VLD_N; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
			res_valid_q <= vld_q[VLD_N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pos_q[0] <= point;
			for (int k = 1; k < POS_N; k++) begin
				pos_q[k] <= pos_q[k-1];
			end
		end
	end

	c2s_square u_sq_x (.clk(clk), .en(advance), .value(point.x_pos), .square(sq_x));
	c2s_square u_sq_y (.clk(clk), .en(advance), .value(point.y_pos), .square(sq_y));
	c2s_square u_sq_z (.clk(clk), .en(advance), .value(point.z_pos), .square(sq_z));

	always_ff @(posedge clk) begin
		if (advance) begin
			pxy_s3  <= (2*CW)'(sq_x) + (2*CW)'(sq_y);
			pall_s3 <= (2*CW)'(sq_x) + (2*CW)'(sq_y) + (2*CW)'(sq_z);
		end
	end

	assign pall_lane[0] = '{rad: pall_s3, rem: '0, root: '0, rnd: '0};
	assign pxy_lane[0]  = '{rad: pxy_s3, rem: '0, root: '0, rnd: '0};

	for (genvar j = 0; j < CW; j++) begin : g_pall
		c2s_sqrt_cell #(.IDX(j)) u_cell (
			.clk     (clk),
			.en      (advance),
			.lane_in (pall_lane[j]),
			.lane_out(pall_lane[j+1])
		);
	end

	for (genvar j = 0; j < RW; j++) begin : g_pxy
		c2s_sqrt_cell #(.IDX(j)) u_cell (
			.clk     (clk),
			.en      (advance),
			.lane_in (pxy_lane[j]),
			.lane_out(pxy_lane[j+1])
		);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			radius_q[0] <= pall_lane[CW].rnd;
			for (int k = 1; k < RAD_D; k++) begin
				radius_q[k] <= radius_q[k-1];
			end
		end
	end

	assign pos_end = pos_q[POS_N-1];

	always_comb begin
		sx   = {{(DP_W-CW){pos_end.x_pos[CW-1]}}, pos_end.x_pos};
		sy   = {{(DP_W-CW){pos_end.y_pos[CW-1]}}, pos_end.y_pos};
		sz   = {{(DP_W-CW){pos_end.z_pos[CW-1]}}, pos_end.z_pos};
		sx   = sx <<< c2s_pkg::SCALE_SHIFT;
		sy   = sy <<< c2s_pkg::SCALE_SHIFT;
		sz   = sz <<< c2s_pkg::SCALE_SHIFT;
		srho = {{(DP_W-RW){1'b0}}, pxy_lane[RW].root};

		side_d.radius        = radius_q[RAD_D-1];
		side_d.planar_radius = pxy_lane[RW].rnd;
		side_d.on_axis       = (pos_end.x_pos == '0) && (pos_end.y_pos == '0);
		side_d.origin        = side_d.on_axis && (pos_end.z_pos == '0);
		side_d.z_neg         = pos_end.z_pos[CW-1];
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			phi_pre_q   <= pre_rotate(sx, sy);
			theta_pre_q <= pre_rotate(sz, srho);
			side_q[0]   <= side_d;
			for (int k = 1; k <= CORDIC_STAGES; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	assign phi_lane[0]   = phi_pre_q;
	assign theta_lane[0] = theta_pre_q;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		c2s_cordic_cell #(.IDX(i)) u_phi (
			.clk     (clk),
			.en      (advance),
			.lane_in (phi_lane[i]),
			.lane_out(phi_lane[i+1])
		);
		c2s_cordic_cell #(.IDX(i)) u_theta (
			.clk     (clk),
			.en      (advance),
			.lane_in (theta_lane[i]),
			.lane_out(theta_lane[i+1])
		);
	end

	always_comb begin
		side_end  = side_q[CORDIC_STAGES];
		phi_acc   = phi_lane[CORDIC_STAGES].acc;
		theta_acc = theta_lane[CORDIC_STAGES].acc;
		phi_rnd   = (phi_acc + c2s_pkg::ANG_RND) >>> c2s_pkg::ANG_SHIFT;
		theta_rnd = (theta_acc + c2s_pkg::ANG_RND) >>> c2s_pkg::ANG_SHIFT;

		res_d.radius        = side_end.radius;
		res_d.planar_radius = side_end.planar_radius;
		res_d.origin_flag   = side_end.origin;
		if (side_end.on_axis) begin
			res_d.azimuth     = '0;
			res_d.polar_angle = side_end.z_neg ? c2s_pkg::PI_CODE : '0;
		end else begin
			res_d.azimuth = phi_rnd[AW-1:0];
			if (theta_rnd < 0) begin
				res_d.polar_angle = '0;
			end else if (theta_rnd > c2s_pkg::PI_ACC) begin
				res_d.polar_angle = c2s_pkg::PI_CODE;
			end else begin
				res_d.polar_angle = theta_rnd[AW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_origin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.origin_flag |->
			res_q.polar_angle == '0 && res_q.azimuth == '0 && res_q.radius == '0)
		else $error("origin result carries a nonzero field");

	a_polar_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> res_q.polar_angle <= c2s_pkg::PI_CODE)
		else $error("polar angle beyond pi");

	a_radius_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> res_q.planar_radius <= res_q.radius)
		else $error("planar radius exceeds radius");

	a_pipe_drain: assert property (@(posedge clk) disable iff (!arst_n)
		advance && vld_q[VLD_N-1] |=> res_valid_q)
		else $error("request lost at the result register");

endmodule

`default_nettype wire
